### hw/rtl/lsbse_pkg.sv
// Shared types and constants for the LSB hide/recover block.
`timescale 1ns / 1ps

package lsbse_pkg;

    localparam int BYTE_BITS = 8;
    localparam int POS_W     = 12;
    localparam int EXP_W     = 9;
    localparam int QDEPTH    = 4;
    localparam int QPW       = 2;
    localparam int QCW       = 3;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_EMBED   = 2'd1,
        MODE_EXTRACT = 2'd2
    } mode_t;

    // one classified request between front and back
    typedef struct packed {
        mode_t       mode;
        logic        restart;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
        logic [1:0]  nbits;
        logic [2:0]  offset;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic        embed_done;
        logic        overflow;
    } req_t;

    typedef struct packed {
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
        logic        pixel_valid;
        logic [7:0]  text_byte;
        logic        byte_valid;
        logic        last_byte;
        logic        done;
        logic        overflow;
    } res_t;

endpackage

### hw/rtl/lsbse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lsbse_front.sv
// Front end: accepts requests, tracks load and embed counters, reads the message store.
`timescale 1ns / 1ps

module lsbse_front #(
    parameter int MAX_MESSAGE_BYTES = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            mode,
    input  logic                  restart,
    input  logic [7:0]            message_byte,
    input  logic [7:0]            channel0_in,
    input  logic [7:0]            channel1_in,
    input  logic [7:0]            channel2_in,
    input  logic [lsbse_pkg::QCW-1:0] q_count,
    output logic                  q_push,
    output lsbse_pkg::req_t       q_data
);

    localparam int AW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam logic [7:0] LC_MAX = 8'(MAX_MESSAGE_BYTES);
    localparam int PW = lsbse_pkg::POS_W;

    lsbse_pkg::mode_t m;
    logic             accept;
    logic [7:0]       lc_reg;
    logic [7:0]       lc_next;
    logic [PW-1:0]    pos_reg;
    logic [PW-1:0]    pos_next;
    logic [7:0]       lc_base;
    logic [PW-1:0]    pos_base;
    logic [PW-1:0]    total;
    logic [PW-1:0]    remain;
    logic [1:0]       nbits;
    logic [PW-1:0]    pos_new;
    logic [8:0]       b0;
    logic             room;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [7:0]       ram_a;
    logic [7:0]       ram_b;
    logic [lsbse_pkg::QCW:0] occ;
    logic             s1_valid_reg;
    lsbse_pkg::req_t  s1_req_reg;
    lsbse_pkg::req_t  s1_req_next;
    logic             s1_use_a_reg;
    logic [PW-1:0]    total_reg;

    assign m = lsbse_pkg::mode_t'(mode);

    assign occ    = {1'b0, q_count} + {{lsbse_pkg::QCW{1'b0}}, s1_valid_reg};
    assign full   = (occ >= (lsbse_pkg::QCW+1)'(lsbse_pkg::QDEPTH));
    assign accept = push && !full;

    always_comb
    begin
        lc_base  = (restart && (m == lsbse_pkg::MODE_LOAD)) ? 8'd0 : lc_reg;
        pos_base = restart ? '0 : pos_reg;
        total    = {1'b0, lc_base, 3'b000} + PW'(lsbse_pkg::BYTE_BITS);
        remain   = total - pos_base;
        nbits    = (remain >= PW'(3)) ? 2'd3 : remain[1:0];
        pos_new  = pos_base + {{(PW-2){1'b0}}, nbits};
        b0       = pos_base[PW-1:3];
        addr_a   = AW'(b0 - 9'd1);
        addr_b   = AW'(b0);
        room     = (lc_base < LC_MAX);
        wr_en    = accept && (m == lsbse_pkg::MODE_LOAD) && room;
        rd_en    = accept && (m == lsbse_pkg::MODE_EMBED);

        lc_next  = lc_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (m)
                lsbse_pkg::MODE_LOAD:
                begin
                    lc_next  = room ? (lc_base + 8'd1) : lc_base;
                    pos_next = pos_base;
                end
                lsbse_pkg::MODE_EMBED:
                begin
                    pos_next = pos_new;
                end
                lsbse_pkg::MODE_EXTRACT:
                begin
                    pos_next = pos_base;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end

        s1_req_next            = '0;
        s1_req_next.mode       = m;
        s1_req_next.restart    = restart;
        s1_req_next.ch0        = channel0_in;
        s1_req_next.ch1        = channel1_in;
        s1_req_next.ch2        = channel2_in;
        s1_req_next.nbits      = nbits;
        s1_req_next.offset     = pos_base[2:0];
        s1_req_next.byte_a     = lc_base;
        s1_req_next.embed_done = (pos_new >= total);
        s1_req_next.overflow   = !room;
    end

    lsbse_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE_BYTES),
        .AW    (AW)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(lc_base)),
        .wdata (message_byte),
        .re    (rd_en),
        .raddr (addr_a),
        .rdata (ram_a)
    );

    lsbse_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE_BYTES),
        .AW    (AW)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(lc_base)),
        .wdata (message_byte),
        .re    (rd_en),
        .raddr (addr_b),
        .rdata (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg       <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            lc_reg       <= lc_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= s1_req_next;
            s1_use_a_reg <= (b0 != 9'd0);
        end
    end

    always_comb
    begin
        q_data        = s1_req_reg;
        q_data.byte_a = s1_use_a_reg ? ram_a : s1_req_reg.byte_a;
        q_data.byte_b = ram_b;
    end

    assign q_push    = s1_valid_reg;
    assign total_reg = {1'b0, lc_reg, 3'b000} + PW'(lsbse_pkg::BYTE_BITS);

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= total_reg)
        else $error("embed position beyond stream end");
    assert property (@(posedge clk) disable iff (!rst_n) lc_reg <= LC_MAX)
        else $error("loaded count beyond store size");

endmodule

### hw/rtl/lsbse_queue.sv
// Short request queue between front end and back end.
`timescale 1ns / 1ps

module lsbse_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lsbse_pkg::req_t           wdata,
    input  logic                      pop,
    output lsbse_pkg::req_t           rdata,
    output logic                      nonempty,
    output logic [lsbse_pkg::QCW-1:0] count
);

    lsbse_pkg::req_t             mem_reg [lsbse_pkg::QDEPTH];
    logic [lsbse_pkg::QPW-1:0]   wr_ptr_reg;
    logic [lsbse_pkg::QPW-1:0]   rd_ptr_reg;
    logic [lsbse_pkg::QCW-1:0]   count_reg;
    logic [lsbse_pkg::QCW-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata    = mem_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign count    = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != lsbse_pkg::QCW'(lsbse_pkg::QDEPTH)) || pop)
        else $error("request queue overrun");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != '0)
        else $error("request queue underrun");

endmodule

### hw/rtl/lsbse_back.sv
// Back end: applies embed bits, runs the extract state, holds the result register.
`timescale 1ns / 1ps

module lsbse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  lsbse_pkg::req_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            pop,
    output lsbse_pkg::res_t res
);

    localparam int PW = lsbse_pkg::POS_W;
    localparam int EW = lsbse_pkg::EXP_W;

    logic             take;
    logic             out_valid_reg;
    lsbse_pkg::res_t  res_reg;
    lsbse_pkg::res_t  res_next;
    logic [PW-1:0]    cnt_reg;
    logic [PW-1:0]    cnt_next;
    logic [7:0]       shift_reg;
    logic [7:0]       shift_next;
    logic [EW-1:0]    exp_reg;
    logic [EW-1:0]    exp_next;
    logic             hdr_reg;
    logic             hdr_next;
    logic             fin_reg;
    logic             fin_next;
    logic [7:0]       ch [3];
    logic [15:0]      window;
    logic [3:0]       idx;
    logic [EW-1:0]    got;

    assign take  = q_valid && (!out_valid_reg || pop);
    assign q_pop = take;

    always_comb
    begin
        ch[0]      = q_data.ch0;
        ch[1]      = q_data.ch1;
        ch[2]      = q_data.ch2;
        window     = {q_data.byte_a, q_data.byte_b};
        idx        = '0;
        got        = '0;
        res_next   = '0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        exp_next   = exp_reg;
        hdr_next   = hdr_reg;
        fin_next   = fin_reg;

        if (q_data.restart && (q_data.mode == lsbse_pkg::MODE_LOAD
            || q_data.mode == lsbse_pkg::MODE_EMBED
            || q_data.mode == lsbse_pkg::MODE_EXTRACT))
        begin
            cnt_next   = '0;
            shift_next = '0;
            exp_next   = '0;
            hdr_next   = 1'b0;
            fin_next   = 1'b0;
        end

        unique case (q_data.mode)
            lsbse_pkg::MODE_LOAD:
            begin
                res_next.overflow = q_data.overflow;
            end
            lsbse_pkg::MODE_EMBED:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (2'(c) < q_data.nbits)
                    begin
                        idx      = {1'b0, q_data.offset} + 4'(c);
                        ch[c][0] = window[4'd15 - idx];
                    end
                end
                res_next.ch0         = ch[0];
                res_next.ch1         = ch[1];
                res_next.ch2         = ch[2];
                res_next.pixel_valid = 1'b1;
                res_next.done        = q_data.embed_done;
            end
            lsbse_pkg::MODE_EXTRACT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (!fin_next)
                    begin
                        shift_next = {shift_next[6:0], ch[c][0]};
                        cnt_next   = cnt_next + 1'b1;
                        if (cnt_next[2:0] == 3'd0)
                        begin
                            if (!hdr_next)
                            begin
                                hdr_next = 1'b1;
                                exp_next = {1'b0, shift_next};
                                if (shift_next == 8'd0)
                                begin
                                    fin_next = 1'b1;
                                end
                            end
                            else
                            begin
                                got                 = cnt_next[PW-1:3] - 1'b1;
                                res_next.text_byte  = shift_next;
                                res_next.byte_valid = 1'b1;
                                if (got >= exp_next)
                                begin
                                    res_next.last_byte = 1'b1;
                                    fin_next           = 1'b1;
                                end
                            end
                        end
                    end
                end
                res_next.done = fin_next;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            exp_reg       <= '0;
            hdr_reg       <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                shift_reg     <= shift_next;
                exp_reg       <= exp_next;
                hdr_reg       <= hdr_next;
                fin_reg       <= fin_next;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.last_byte |-> res_reg.byte_valid && res_reg.done)
        else $error("last byte without byte valid or done");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.pixel_valid |-> !res_reg.byte_valid)
        else $error("pixel and text byte in one result");

endmodule

### hw/rtl/lsb_stego_embed_extract.sv
// Top level of the LSB message hide/recover block.
`timescale 1ns / 1ps
//
// Both sides look like a queue. A request is taken on a rising edge with
// push high and full low; mode selects load (store message_byte), embed
// (replace channel LSBs with the length header then message bits, MSB first)
// or extract (collect LSBs, emit the message bytes). restart begins a new
// pass, and in load mode a new message.
// A result waits on the output ports while empty is low and leaves on an
// edge with pop high. Every accepted request gives exactly one result.
// A taken request goes through the store-read stage, queue and result register.
// Throughput: one request per clock while full is low; two RAM copies read
// the message store at accept time, so a pixel's bits come from one read.
// A four-entry request queue sits between front end and back end; when the
// receiver stalls the result register holds, the queue fills, and full rises
// once the queue and the store-read stage hold four requests.
// Reset clears the load count, embed and extract state and the request queue;
// no clearing pass is run, message store contents are undefined until loaded.
//

module lsb_stego_embed_extract #(
    parameter int MAX_MESSAGE_BYTES = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic       restart,
    input  logic [7:0] message_byte,
    input  logic [7:0] channel0_in,
    input  logic [7:0] channel1_in,
    input  logic [7:0] channel2_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] channel0_out,
    output logic [7:0] channel1_out,
    output logic [7:0] channel2_out,
    output logic       pixel_valid,
    output logic [7:0] text_byte,
    output logic       byte_valid,
    output logic       last_byte,
    output logic       done_res,
    output logic       load_overflow
);

    logic                      q_push;
    lsbse_pkg::req_t           q_wdata;
    logic                      q_pop;
    lsbse_pkg::req_t           q_rdata;
    logic                      q_nonempty;
    logic [lsbse_pkg::QCW-1:0] q_count;
    logic                      out_valid;
    lsbse_pkg::res_t           res;

    lsbse_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .restart      (restart),
        .message_byte (message_byte),
        .channel0_in  (channel0_in),
        .channel1_in  (channel1_in),
        .channel2_in  (channel2_in),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    lsbse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .nonempty (q_nonempty),
        .count    (q_count)
    );

    lsbse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .pop       (pop),
        .res       (res)
    );

    assign empty         = !out_valid;
    assign channel0_out  = res.ch0;
    assign channel1_out  = res.ch1;
    assign channel2_out  = res.ch2;
    assign pixel_valid   = res.pixel_valid;
    assign text_byte     = res.text_byte;
    assign byte_valid    = res.byte_valid;
    assign last_byte     = res.last_byte;
    assign done_res      = res.done;
    assign load_overflow = res.overflow;

endmodule
